// File: rtl/pmsp_pkg.sv
// Shared types, constants and codes for the pedal to motor setpoint block.
package pmsp_pkg;

  // Field and arithmetic widths.
  localparam int ADC_W = 12;
  localparam int Q_W = 16;
  localparam int DIV_STEPS = 15;
  localparam int STEP_W = $clog2(DIV_STEPS);

  // Fixed-point constants.
  localparam logic [Q_W-1:0] FULL_SCALE = 16'd32768;
  localparam logic [Q_W-1:0] REGEN_SLEW = 16'd164;
  // Largest pedal current that does not exceed one tenth of full scale.
  localparam logic [Q_W-1:0] PEDAL_TENTH = 16'd3276;

  // Default fault windows.
  localparam logic [ADC_W-1:0] PEDAL_FAULT_LOW_DEF = 12'd100;
  localparam logic [ADC_W-1:0] PEDAL_FAULT_HIGH_DEF = 12'd4000;
  localparam logic [ADC_W-1:0] REGEN_FAULT_LOW_DEF = 12'd100;
  localparam logic [ADC_W-1:0] REGEN_FAULT_HIGH_DEF = 12'd4000;

  // Drive modes that command current.
  localparam logic [3:0] MODE_REVERSE = 4'd4;
  localparam logic [3:0] MODE_DRIVE_LOW = 4'd5;
  localparam logic [3:0] MODE_DRIVE_HIGH = 4'd6;
  localparam logic [3:0] MODE_BRAKE_LOW = 4'd7;

  // Register indexes.
  localparam logic [2:0] REG_PEDAL_MIN = 3'd0;
  localparam logic [2:0] REG_PEDAL_SPAN = 3'd1;
  localparam logic [2:0] REG_REGEN_MIN = 3'd2;
  localparam logic [2:0] REG_REGEN_SPAN = 3'd3;
  localparam logic [2:0] REG_REGEN_GAIN = 3'd4;
  localparam logic [2:0] REG_CRUISE_GAIN = 3'd5;
  localparam logic [2:0] REG_FWD_LIMIT = 3'd6;
  localparam logic [2:0] REG_REV_LIMIT = 3'd7;

  // Divider operand select.
  localparam logic [1:0] SEL_PEDAL = 2'd0;
  localparam logic [1:0] SEL_REGEN = 2'd1;
  localparam logic [1:0] SEL_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_CRUISE,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic [ADC_W-1:0] pedal_a;
    logic [ADC_W-1:0] regen_pot;
    logic [3:0] drive_mode;
    logic signed [15:0] motor_speed;
    logic signed [15:0] cruise_target;
    logic [15:0] battery_volts;
    logic [15:0] phase_volts;
    logic signed [15:0] phase_amps;
  } in_item_t;

  typedef struct packed {
    logic [15:0] current_setpoint;
    logic signed [15:0] speed_setpoint;
    logic [3:0] fault_bits;
    logic current_clipped;
  } out_item_t;

endpackage

// File: rtl/pedal_to_motor_setpoint_core.sv
// Pedal to motor setpoint core: sequencer around one shared divider and multiplier.
//
// Usage:
//   The input channel takes one sample beat (in_item) when in_valid is high and
//   in_stall is low. The output channel presents one result beat (out_item) with
//   out_valid; it is taken when out_stall is low. Configuration registers sit on
//   an APB-style port at byte addresses 4*i and may be written while idle.
// Sequence:
//   A fault-free sample runs from accept to result through one check state,
//   one multiply, three divisions of a load state and the restoring steps
//   each, one multiply for the cruise term and one finish state. The three
//   restoring divisions go through the single shared divider; a division
//   whose answer saturates or is zero finishes in its load state. A faulted
//   sample goes from the check state straight to the finish state. One
//   sample is in work at a time, and in_stall is high while it is.
// Reset:
//   rst clears the registers to their defaults, the regen slew memory to zero
//   and the output channel to empty.
// Stall:
//   A finished result waits in the output register; the next sample is taken
//   meanwhile and holds in its finish cycle until the output register is free.
module pedal_to_motor_setpoint_core
  import pmsp_pkg::*;
#(
  parameter logic [ADC_W-1:0] PEDAL_FAULT_LOW = PEDAL_FAULT_LOW_DEF,
  parameter logic [ADC_W-1:0] PEDAL_FAULT_HIGH = PEDAL_FAULT_HIGH_DEF,
  parameter logic [ADC_W-1:0] REGEN_FAULT_LOW = REGEN_FAULT_LOW_DEF,
  parameter logic [ADC_W-1:0] REGEN_FAULT_HIGH = REGEN_FAULT_HIGH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_item,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  // Configuration registers.
  logic [ADC_W-1:0] pedal_dead_band, pedal_travel_span;
  logic [ADC_W-1:0] regen_dead_band, regen_travel_span;
  logic [15:0] regen_limit_gain, cruise_gain;
  logic [14:0] forward_speed_limit;
  logic signed [15:0] reverse_speed_limit;

  // Sequencer and datapath registers.
  state_t state, state_next;
  in_item_t item;
  logic [1:0] sel;
  logic [STEP_W-1:0] cnt;
  logic [15:0] rem;
  logic [DIV_STEPS-1:0] quo;
  logic [DIV_STEPS-1:0] lo;
  logic [15:0] div;
  logic [31:0] prod;
  logic [15:0] pedal_cur, regen_cur, lim_cur;
  logic [15:0] last_regen;
  logic [3:0] faults;

  logic cfg_write, out_free;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_dead_band <= 12'd300;
      pedal_travel_span <= 12'd3500;
      regen_dead_band <= 12'd300;
      regen_travel_span <= 12'd3500;
      regen_limit_gain <= 16'd16384;
      cruise_gain <= 16'd230;
      forward_speed_limit <= 15'd20000;
      reverse_speed_limit <= -16'sd20000;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PEDAL_MIN: pedal_dead_band <= pwdata[ADC_W-1:0];
        REG_PEDAL_SPAN: pedal_travel_span <= pwdata[ADC_W-1:0];
        REG_REGEN_MIN: regen_dead_band <= pwdata[ADC_W-1:0];
        REG_REGEN_SPAN: regen_travel_span <= pwdata[ADC_W-1:0];
        REG_REGEN_GAIN: regen_limit_gain <= pwdata[15:0];
        REG_CRUISE_GAIN: cruise_gain <= pwdata[15:0];
        REG_FWD_LIMIT: forward_speed_limit <= pwdata[14:0];
        REG_REV_LIMIT: reverse_speed_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_PEDAL_MIN: prdata = {20'd0, pedal_dead_band};
      REG_PEDAL_SPAN: prdata = {20'd0, pedal_travel_span};
      REG_REGEN_MIN: prdata = {20'd0, regen_dead_band};
      REG_REGEN_SPAN: prdata = {20'd0, regen_travel_span};
      REG_REGEN_GAIN: prdata = {16'd0, regen_limit_gain};
      REG_CRUISE_GAIN: prdata = {16'd0, cruise_gain};
      REG_FWD_LIMIT: prdata = {17'd0, forward_speed_limit};
      REG_REV_LIMIT: prdata = {{16{reverse_speed_limit[15]}}, reverse_speed_limit};
      default: prdata = 32'd0;
    endcase
  end

  // Fault window check on the held sample.
  logic [3:0] fault_now;
  always_comb begin
    fault_now[0] = item.pedal_a < PEDAL_FAULT_LOW;
    fault_now[1] = item.pedal_a > PEDAL_FAULT_HIGH;
    fault_now[2] = item.regen_pot < REGEN_FAULT_LOW;
    fault_now[3] = item.regen_pot > REGEN_FAULT_HIGH;
  end

  // Cruise speed error magnitude.
  logic below;
  logic signed [16:0] diff;
  logic [15:0] err;
  always_comb begin
    below = item.motor_speed < item.cruise_target;
    diff = 17'(item.cruise_target) - 17'(item.motor_speed);
    err = below ? diff[15:0] : 16'(-diff);
  end

  // Shared multiplier operands.
  logic [15:0] mul_a, mul_b;
  always_comb begin
    if (state == ST_MUL) begin
      mul_a = item.battery_volts;
      mul_b = regen_limit_gain;
    end else begin
      mul_a = cruise_gain;
      mul_b = err;
    end
  end

  // Divider load: pick the operands and catch zero and saturated answers.
  logic [ADC_W-1:0] ld_adc, ld_min, ld_span, ld_travel;
  logic ld_done;
  logic [15:0] ld_result, ld_rem, ld_div;
  logic [DIV_STEPS-1:0] ld_lo;
  always_comb begin
    ld_adc = (sel == SEL_PEDAL) ? item.pedal_a : item.regen_pot;
    ld_min = (sel == SEL_PEDAL) ? pedal_dead_band : regen_dead_band;
    ld_span = (sel == SEL_PEDAL) ? pedal_travel_span : regen_travel_span;
    ld_travel = (ld_adc > ld_min) ? ld_adc - ld_min : '0;
    if (sel == SEL_LIMIT) begin
      ld_div = item.phase_volts;
      ld_rem = prod[30:DIV_STEPS];
      ld_lo = prod[DIV_STEPS-1:0];
      ld_done = prod >= {1'b0, item.phase_volts, 15'd0};
      ld_result = FULL_SCALE;
    end else begin
      ld_div = 16'(ld_span);
      ld_rem = 16'(ld_travel);
      ld_lo = '0;
      ld_done = (ld_travel == '0) || (ld_travel >= ld_span);
      ld_result = (ld_travel == '0) ? 16'd0 : FULL_SCALE;
    end
  end

  // One restoring division step.
  logic [16:0] trial;
  logic step_ok;
  logic [15:0] rem_step;
  logic [DIV_STEPS-1:0] quo_step;
  always_comb begin
    trial = {rem, lo[DIV_STEPS-1]} - {1'b0, div};
    step_ok = !trial[16];
    rem_step = step_ok ? trial[15:0] : {rem[14:0], lo[DIV_STEPS-1]};
    quo_step = {quo[DIV_STEPS-2:0], step_ok};
  end

  // Finish: regen limit and slew, then the drive mode decision.
  logic [15:0] regen_lim, regen;
  logic [16:0] slew;
  logic signed [25:0] cruise_v;
  out_item_t result;
  always_comb begin
    regen_lim = (regen_cur > lim_cur) ? lim_cur : regen_cur;
    slew = 17'(last_regen) + 17'(REGEN_SLEW);
    regen = (17'(regen_lim) > slew) ? slew[15:0] : regen_lim;
    cruise_v = $signed({2'b00, prod[31:8]}) + 26'(item.phase_amps);
    result.current_setpoint = 16'd0;
    result.speed_setpoint = 16'sd0;
    result.fault_bits = fault_now;
    result.current_clipped = 1'b0;
    if (fault_now == 4'd0) begin
      if (item.drive_mode == MODE_REVERSE || item.drive_mode == MODE_DRIVE_LOW) begin
        if (regen == 16'd0) begin
          result.current_setpoint = pedal_cur;
          result.speed_setpoint = (item.drive_mode == MODE_REVERSE) ?
                                  reverse_speed_limit : {1'b0, forward_speed_limit};
        end else begin
          result.current_setpoint = regen;
        end
      end else if (item.drive_mode == MODE_DRIVE_HIGH ||
                   item.drive_mode == MODE_BRAKE_LOW) begin
        if (regen != 16'd0) begin
          result.current_setpoint = regen;
        end else if (pedal_cur > PEDAL_TENTH) begin
          result.current_setpoint = pedal_cur;
          result.speed_setpoint = {1'b0, forward_speed_limit};
        end else begin
          result.speed_setpoint = item.cruise_target;
          if (cruise_v > 26'sd32768) begin
            result.current_setpoint = FULL_SCALE;
            result.current_clipped = 1'b1;
            if (below) begin
              result.speed_setpoint = {1'b0, forward_speed_limit};
            end
          end else if (cruise_v < 26'sd0) begin
            result.current_clipped = 1'b1;
          end else begin
            result.current_setpoint = cruise_v[15:0];
          end
        end
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = (fault_now != 4'd0) ? ST_FINAL : ST_MUL;
      end
      ST_MUL: state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: begin
        if (!ld_done) state_next = ST_DIV_RUN;
        else if (sel == SEL_LIMIT) state_next = ST_CRUISE;
      end
      ST_DIV_RUN: begin
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          state_next = (sel == SEL_LIMIT) ? ST_CRUISE : ST_DIV_LOAD;
        end
      end
      ST_CRUISE: state_next = ST_FINAL;
      ST_FINAL: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item <= in_item;
    end
    if (state == ST_MUL || state == ST_CRUISE) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_CHECK) begin
      sel <= SEL_PEDAL;
    end
    if (state == ST_DIV_LOAD) begin
      rem <= ld_rem;
      lo <= ld_lo;
      div <= ld_div;
      quo <= '0;
      cnt <= '0;
      if (ld_done) begin
        sel <= sel + 2'd1;
        unique case (sel)
          SEL_PEDAL: pedal_cur <= ld_result;
          SEL_REGEN: regen_cur <= ld_result;
          default: lim_cur <= ld_result;
        endcase
      end
    end
    if (state == ST_DIV_RUN) begin
      rem <= rem_step;
      lo <= {lo[DIV_STEPS-2:0], 1'b0};
      quo <= quo_step;
      cnt <= cnt + STEP_W'(1);
      if (cnt == STEP_W'(DIV_STEPS - 1)) begin
        sel <= sel + 2'd1;
        unique case (sel)
          SEL_PEDAL: pedal_cur <= {1'b0, quo_step};
          SEL_REGEN: regen_cur <= {1'b0, quo_step};
          default: lim_cur <= {1'b0, quo_step};
        endcase
      end
    end
    if (state == ST_FINAL && out_free) begin
      out_item <= result;
    end
  end

  // Regen slew memory and output beat valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_regen <= 16'd0;
      out_valid <= 1'b0;
      faults <= 4'd0;
    end else begin
      if (state == ST_FINAL && out_free) begin
        out_valid <= 1'b1;
        faults <= fault_now;
        if (fault_now == 4'd0) last_regen <= regen;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A faulted beat commands zero current and zero speed.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.fault_bits != 4'd0 |->
      out_item.current_setpoint == 16'd0 && out_item.speed_setpoint == 16'sd0)
    else $error("faulted beat commands motion");

  // Current never exceeds full scale.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.current_setpoint <= FULL_SCALE)
    else $error("current setpoint above full scale");

  // Stored regen stays within full scale.
  assert property (@(posedge clk) disable iff (rst)
    last_regen <= FULL_SCALE)
    else $error("regen memory above full scale");

  // Recorded fault bits match the beat that was loaded.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_item.fault_bits == faults)
    else $error("fault bits lost on the way out");

endmodule
